// ===== sv/adcsq_pkg.sv =====
package adcsq_pkg;

    // Structure of the block
    localparam int NUM_SEQ        = 4;
    localparam int FIFO_DEPTH_DEF = 16;
    localparam int SAMPLE_BITS    = 3;

    // Operation codes carried in tuser
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TRIG  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Constants of the register model
    localparam logic [31:0] NOISE_MUL   = 32'd314159;
    localparam logic [31:0] SAMPLE_BASE = 32'h0000_0200;
    localparam logic [31:0] ID_VALUE    = 32'h00b0_20c7;
    localparam logic [31:0] PRIO_RESET  = 32'h0000_3210;
    localparam logic [31:0] PCFG_RESET  = 32'h0000_0007;
    localparam logic [3:0]  TRIG_TIMER  = 4'd5;

    // Register offsets
    localparam logic [11:0] R_ACTSS  = 12'h000;
    localparam logic [11:0] R_RIS    = 12'h004;
    localparam logic [11:0] R_IM     = 12'h008;
    localparam logic [11:0] R_ISC    = 12'h00c;
    localparam logic [11:0] R_OSTAT  = 12'h010;
    localparam logic [11:0] R_EMUX   = 12'h014;
    localparam logic [11:0] R_USTAT  = 12'h018;
    localparam logic [11:0] R_TSSEL  = 12'h01c;
    localparam logic [11:0] R_SSPRI  = 12'h020;
    localparam logic [11:0] R_SPC    = 12'h024;
    localparam logic [11:0] R_SAC    = 12'h030;
    localparam logic [11:0] R_DCISC  = 12'h034;
    localparam logic [11:0] R_CTL    = 12'h038;
    localparam logic [11:0] R_DCRIC  = 12'hd00;
    localparam logic [11:0] R_PERID  = 12'hfc0;
    localparam logic [11:0] R_PC     = 12'hfc4;
    localparam logic [11:0] R_CC     = 12'hfc8;

    // Sequencer sub-offsets
    localparam logic [4:0] S_MUX  = 5'h00;
    localparam logic [4:0] S_CTL  = 5'h04;
    localparam logic [4:0] S_FIFO = 5'h08;
    localparam logic [4:0] S_FSTA = 5'h0c;
    localparam logic [4:0] S_OP   = 5'h10;
    localparam logic [4:0] S_DC   = 5'h14;

    // Controller to datapath commands
    typedef struct packed {
        logic       latch;
        logic       access;
        logic       pop_load;
        logic       trig;
        logic [1:0] seq;
        logic       load_out;
    } adcsq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_pop;
        logic is_trig;
        logic out_free;
    } adcsq_stat_t;

endpackage

// ===== sv/adcsq_ram.sv =====
module adcsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/adcsq_datapath.sv =====
module adcsq_datapath
    import adcsq_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  adcsq_cmd_t  cmd,
    output adcsq_stat_t stat,
    input  logic [1:0]  in_op,
    input  logic [11:0] in_off,
    input  logic [31:0] in_wdata,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [31:0] out_rdata,
    output logic [3:0]  out_irq
);

    localparam int PW       = $clog2(FIFO_DEPTH);
    localparam int RAM_AW   = PW + 2;
    localparam int RAM_DEPTH = NUM_SEQ << PW;

    // Latched transaction
    logic [1:0]  op_reg;
    logic [11:0] off_reg;
    logic [31:0] wdata_reg;

    // Architectural registers
    logic [3:0]  active_reg, raw_reg, ovf_reg, unf_reg;
    logic [31:0] im_reg, emux_reg, tssel_reg, pri_reg, spc_reg, sac_reg;
    logic [31:0] dcisc_reg, ctl_reg, dcric_reg, pc_reg, cc_reg, noise_reg;
    logic [31:0] smux_reg [NUM_SEQ];
    logic [31:0] sctl_reg [NUM_SEQ];
    logic [31:0] sop_reg  [NUM_SEQ];
    logic [31:0] sdc_reg  [NUM_SEQ];
    logic [31:0] cmpc_reg [8];
    logic [31:0] cmpr_reg [8];
    logic [PW-1:0] tail_reg [NUM_SEQ];
    logic [PW-1:0] head_reg [NUM_SEQ];
    logic [NUM_SEQ-1:0] empty_reg, full_reg;
    logic [RAM_DEPTH-1:0] valid_reg;
    logic valid_q_reg;

    // Result registers
    logic [31:0] rdata_reg;
    logic        out_valid_reg;
    logic [31:0] out_rdata_reg;
    logic [3:0]  out_irq_reg;

    // Decode
    logic        in_seq, in_cmpc, in_cmpr;
    logic [1:0]  sn;
    logic [4:0]  sub;
    logic [2:0]  cidx;
    logic [31:0] rd_comb;
    logic [31:0] noise_next;
    logic [PW-1:0] head_next, tail_next;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic        push_hit;
    logic [RAM_AW-1:0] raddr, waddr;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(FIFO_DEPTH - 1))
            r = '0;
        else
            r = p + PW'(1);
        return r;
    endfunction

    function automatic logic [3:0] tssel_placeholder(input logic [31:0] v,
                                                     input logic [1:0] n);
        logic [3:0] f;
        f = v[4*n +: 4];
        return f;
    endfunction

    assign in_seq  = (off_reg[11:8] == 4'h0) && (off_reg[7:6] != 2'b00)
                  && (off_reg[7:6] != 2'b11);
    assign sn      = off_reg[6:5] - 2'd2;
    assign sub     = off_reg[4:0];
    assign in_cmpc = (off_reg[11:5] == 7'h70);
    assign in_cmpr = (off_reg[11:5] == 7'h72);
    assign cidx    = off_reg[4:2];

    assign stat.is_pop   = (op_reg == OP_READ) && in_seq && (sub == S_FIFO);
    assign stat.is_trig  = (op_reg == OP_TRIG);
    assign stat.out_free = !out_valid_reg || out_ready;

    // Noise generator and push target
    assign noise_next = 32'(noise_reg * NOISE_MUL) + 32'd1;
    assign push_hit   = active_reg[cmd.seq]
                     && (tssel_placeholder(emux_reg, cmd.seq) == TRIG_TIMER);
    assign head_next  = ptr_inc(head_reg[cmd.seq]);
    assign tail_next  = ptr_inc(tail_reg[sn]);
    assign raddr      = {sn, tail_reg[sn]};
    assign waddr      = {cmd.seq, head_reg[cmd.seq]};

    adcsq_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.trig && push_hit && !full_reg[cmd.seq]),
        .waddr (waddr),
        .wdata (noise_next[18:16]),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Read multiplexer
    always_comb
    begin
        rd_comb = '0;
        if (op_reg == OP_READ)
        begin
            if (in_seq)
            begin
                case (sub)
                    S_MUX:   rd_comb = smux_reg[sn];
                    S_CTL:   rd_comb = sctl_reg[sn];
                    S_FSTA:  rd_comb = {19'd0, full_reg[sn], 3'd0, empty_reg[sn],
                                        4'(head_reg[sn]), 4'(tail_reg[sn])};
                    S_OP:    rd_comb = sop_reg[sn];
                    S_DC:    rd_comb = sdc_reg[sn];
                    default: rd_comb = '0;
                endcase
            end
            else if (in_cmpc)
                rd_comb = cmpc_reg[cidx];
            else if (in_cmpr)
                rd_comb = cmpr_reg[cidx];
            else
            begin
                unique case (off_reg)
                    R_ACTSS: rd_comb = {28'd0, active_reg};
                    R_RIS:   rd_comb = {28'd0, raw_reg};
                    R_IM:    rd_comb = im_reg;
                    R_ISC:   rd_comb = {28'd0, raw_reg} & im_reg;
                    R_OSTAT: rd_comb = {28'd0, ovf_reg};
                    R_EMUX:  rd_comb = emux_reg;
                    R_USTAT: rd_comb = {28'd0, unf_reg};
                    R_TSSEL: rd_comb = tssel_reg;
                    R_SSPRI: rd_comb = pri_reg;
                    R_SPC:   rd_comb = spc_reg;
                    R_SAC:   rd_comb = sac_reg;
                    R_DCISC: rd_comb = dcisc_reg;
                    R_CTL:   rd_comb = ctl_reg;
                    R_PERID: rd_comb = ID_VALUE;
                    R_PC:    rd_comb = pc_reg;
                    R_CC:    rd_comb = cc_reg;
                    default: rd_comb = '0;
                endcase
            end
        end
    end

    // Latch the incoming transaction
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= in_op;
            off_reg   <= in_off;
            wdata_reg <= in_wdata;
        end
    end

    // Read data: plain registers at access, FIFO entry in the cycle after
    always_ff @(posedge clk)
    begin
        if (cmd.access)
            rdata_reg <= rd_comb;
        else if (cmd.pop_load)
            rdata_reg <= valid_q_reg ? (SAMPLE_BASE | 32'(ram_rdata)) : '0;
    end

    // Register file, FIFO pointers and noise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            raw_reg     <= '0;
            ovf_reg     <= '0;
            unf_reg     <= '0;
            im_reg      <= '0;
            emux_reg    <= '0;
            tssel_reg   <= '0;
            pri_reg     <= PRIO_RESET;
            spc_reg     <= '0;
            sac_reg     <= '0;
            dcisc_reg   <= '0;
            ctl_reg     <= '0;
            dcric_reg   <= '0;
            pc_reg      <= PCFG_RESET;
            cc_reg      <= '0;
            noise_reg   <= '0;
            empty_reg   <= '1;
            full_reg    <= '0;
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
            for (int i = 0; i < NUM_SEQ; i++)
            begin
                smux_reg[i] <= '0;
                sctl_reg[i] <= '0;
                sop_reg[i]  <= '0;
                sdc_reg[i]  <= '0;
                tail_reg[i] <= '0;
                head_reg[i] <= '0;
            end
            for (int i = 0; i < 8; i++)
            begin
                cmpc_reg[i] <= '0;
                cmpr_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.access)
            begin
                valid_q_reg <= valid_reg[raddr];
                // Pop on a FIFO read
                if (stat.is_pop)
                begin
                    if (empty_reg[sn])
                        unf_reg[sn] <= 1'b1;
                    else
                    begin
                        tail_reg[sn] <= tail_next;
                        full_reg[sn] <= 1'b0;
                        if (tail_next == head_reg[sn])
                            empty_reg[sn] <= 1'b1;
                    end
                end
                // Bus write
                if (op_reg == OP_WRITE)
                begin
                    if (in_seq)
                    begin
                        case (sub)
                            S_MUX:   smux_reg[sn] <= wdata_reg;
                            S_CTL:   sctl_reg[sn] <= wdata_reg;
                            S_OP:    sop_reg[sn]  <= wdata_reg;
                            S_DC:    sdc_reg[sn]  <= wdata_reg;
                            default: ;
                        endcase
                    end
                    else if (in_cmpc)
                        cmpc_reg[cidx] <= wdata_reg;
                    else if (in_cmpr)
                        cmpr_reg[cidx] <= wdata_reg;
                    else
                    begin
                        unique case (off_reg)
                            R_ACTSS: active_reg <= wdata_reg[3:0];
                            R_IM:    im_reg     <= wdata_reg;
                            R_ISC:   raw_reg    <= raw_reg & ~wdata_reg[3:0];
                            R_OSTAT: ovf_reg    <= ovf_reg & ~wdata_reg[3:0];
                            R_EMUX:  emux_reg   <= wdata_reg;
                            R_USTAT: unf_reg    <= unf_reg & ~wdata_reg[3:0];
                            R_TSSEL: tssel_reg  <= wdata_reg;
                            R_SSPRI: pri_reg    <= wdata_reg;
                            R_SPC:   spc_reg    <= wdata_reg;
                            R_SAC:   sac_reg    <= wdata_reg;
                            R_DCISC: dcisc_reg  <= wdata_reg;
                            R_CTL:   ctl_reg    <= wdata_reg;
                            R_DCRIC: dcric_reg  <= wdata_reg;
                            R_PC:    pc_reg     <= wdata_reg;
                            R_CC:    cc_reg     <= wdata_reg;
                            default: ;
                        endcase
                    end
                end
            end
            // One sequencer per trigger step
            if (cmd.trig && push_hit)
            begin
                noise_reg         <= noise_next;
                raw_reg[cmd.seq]  <= 1'b1;
                if (full_reg[cmd.seq])
                    ovf_reg[cmd.seq] <= 1'b1;
                else
                begin
                    valid_reg[waddr]   <= 1'b1;
                    head_reg[cmd.seq]  <= head_next;
                    empty_reg[cmd.seq] <= 1'b0;
                    if (tail_reg[cmd.seq] == head_next)
                        full_reg[cmd.seq] <= 1'b1;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_rdata_reg <= rdata_reg;
            out_irq_reg   <= raw_reg & im_reg[3:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rdata = out_rdata_reg;
    assign out_irq   = out_irq_reg;

    // A FIFO is never full and empty at once
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg & empty_reg) == '0)
        else $error("FIFO flagged full and empty");

    // A pop never moves a head pointer
    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.access && stat.is_pop) |=> (head_reg[0] == $past(head_reg[0])
            && head_reg[3] == $past(head_reg[3]) && head_reg[1] == $past(head_reg[1])
            && head_reg[2] == $past(head_reg[2])))
        else $error("head moved on a pop");

    // Result is never loaded over one still waiting
    a_out_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overrun");

endmodule

// ===== sv/adcsq_ctrl.sv =====
module adcsq_ctrl
    import adcsq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  adcsq_stat_t stat,
    output adcsq_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_POP  = 3'd2;
    localparam logic [2:0] ST_TRIG = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] seq_reg, seq_next;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        seq_next     = seq_reg;
        cmd          = '0;
        cmd.seq      = seq_reg;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.access = 1'b1;
                seq_next   = 2'd0;
                if (stat.is_pop)
                    state_next = ST_POP;
                else if (stat.is_trig)
                    state_next = ST_TRIG;
                else
                    state_next = ST_DONE;
            end
            ST_POP:
            begin
                cmd.pop_load = 1'b1;
                state_next   = ST_DONE;
            end
            ST_TRIG:
            begin
                cmd.trig = 1'b1;
                seq_next = seq_reg + 2'd1;
                if (seq_reg == 2'd3)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seq_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
        end
    end

    // The trigger walk always visits four sequencers from the first
    a_trig_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && stat.is_trig) |=> (state_reg == ST_TRIG && seq_reg == 2'd0))
        else $error("trigger walk did not start at sequencer zero");

    a_trig_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRIG && seq_reg == 2'd3) |=> (state_reg == ST_DONE))
        else $error("trigger walk did not end");

endmodule

// ===== sv/adc_sequencer_fifo_registers.sv =====
// Channel   Dir  Signals                         Content
// s_axis    in   s_tvalid s_tready s_tdata s_tuser  offset, write_data; operation
// m_axis    out  m_tvalid m_tready m_tdata          read_data, irq_lines
//
// A FIFO pop adds a step for the registered RAM read, and a timer trigger walks
// the four sequencers in turn (one noise multiply and push per armed sequencer).
// A new transaction is taken while the previous result waits in the output
// register; a stalled result holds the block at its final step.
// rst_n is asynchronous, active low; FIFO entries never written read as zero.
module adc_sequencer_fifo_registers
    import adcsq_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // offset[11:0], write_data[43:12], zero fill
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // read_data[31:0], irq_lines[35:32], zero fill
);

    adcsq_cmd_t  cmd;
    adcsq_stat_t stat;
    logic [31:0] rdata;
    logic [3:0]  irq;

    adcsq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    adcsq_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (s_tuser),
        .in_off    (s_tdata[11:0]),
        .in_wdata  (s_tdata[43:12]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_rdata (rdata),
        .out_irq   (irq)
    );

    assign m_tdata = {4'd0, irq, rdata};

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import adcsq_pkg::*;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] offset;
        logic [31:0] wdata;
    } bus_txn_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic [3:0]  irq;
    } bus_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    adc_sequencer_fifo_registers #(.FIFO_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Shadow register state
    logic [31:0] act_m, ris_m, im_m, ostat_m, ustat_m, emux_m, tssel_m, pri_m;
    logic [31:0] spc_m, sac_m, dcisc_m, ctl_m, dcric_m, pc_m, cc_m, noise_m;
    logic [31:0] smux_m [4];
    logic [31:0] sctl_m [4];
    logic [31:0] sop_m [4];
    logic [31:0] sdc_m [4];
    logic [31:0] cmpc_m [8];
    logic [31:0] cmpr_m [8];
    logic [31:0] fifo_m [4][DEPTH];
    logic [3:0]  tail_m [4];
    logic [3:0]  head_m [4];
    logic        empty_m [4];
    logic        full_m [4];

    bus_txn_t pending_txns[$];
    bus_rsp_t expected_rsps[$];
    int       errors;
    int       rsp_count;
    int       n_reads, n_writes, n_trigs;
    int       drv_gap, mon_gap;

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic reset_shadow();
        act_m = 0; ris_m = 0; im_m = 0; ostat_m = 0; ustat_m = 0; emux_m = 0;
        tssel_m = 0; pri_m = PRIO_RESET; spc_m = 0; sac_m = 0; dcisc_m = 0;
        ctl_m = 0; dcric_m = 0; pc_m = PCFG_RESET; cc_m = 0; noise_m = 0;
        for (int n = 0; n < 4; n++)
        begin
            smux_m[n] = 0; sctl_m[n] = 0; sop_m[n] = 0; sdc_m[n] = 0;
            tail_m[n] = 0; head_m[n] = 0; empty_m[n] = 1; full_m[n] = 0;
            for (int i = 0; i < DEPTH; i++) fifo_m[n][i] = 0;
        end
        for (int i = 0; i < 8; i++)
        begin
            cmpc_m[i] = 0; cmpr_m[i] = 0;
        end
    endtask

    // Pop one sample, flagging underflow on an empty FIFO
    function automatic logic [31:0] pop_sample(int n);
        logic [31:0] v;
        v = fifo_m[n][tail_m[n]];
        if (empty_m[n])
            ustat_m[n] = 1'b1;
        else
        begin
            tail_m[n] = tail_m[n] + 4'd1;
            full_m[n] = 0;
            if (tail_m[n] == head_m[n]) empty_m[n] = 1;
        end
        return v;
    endfunction

    function automatic logic [31:0] read_reg(logic [11:0] off);
        int n;
        n = ((off - 12'h040) >> 5) & 3;
        if (off >= 12'h040 && off < 12'h0c0)
        begin
            case (off[4:0])
                S_MUX:  return smux_m[n];
                S_CTL:  return sctl_m[n];
                S_FIFO: return pop_sample(n);
                S_FSTA: return {19'd0, full_m[n], 3'd0, empty_m[n], head_m[n], tail_m[n]};
                S_OP:   return sop_m[n];
                S_DC:   return sdc_m[n];
                default: return 0;
            endcase
        end
        if (off >= 12'he00 && off <= 12'he1f) return cmpc_m[off[4:2]];
        if (off >= 12'he40 && off <= 12'he5f) return cmpr_m[off[4:2]];
        case (off)
            R_ACTSS: return act_m;
            R_RIS:   return ris_m;
            R_IM:    return im_m;
            R_ISC:   return ris_m & im_m;
            R_OSTAT: return ostat_m;
            R_EMUX:  return emux_m;
            R_USTAT: return ustat_m;
            R_TSSEL: return tssel_m;
            R_SSPRI: return pri_m;
            R_SPC:   return spc_m;
            R_SAC:   return sac_m;
            R_DCISC: return dcisc_m;
            R_CTL:   return ctl_m;
            R_PERID: return ID_VALUE;
            R_PC:    return pc_m;
            R_CC:    return cc_m;
            default: return 0;
        endcase
    endfunction

    task automatic write_reg(logic [11:0] off, logic [31:0] v);
        int n;
        n = ((off - 12'h040) >> 5) & 3;
        if (off >= 12'h040 && off < 12'h0c0)
        begin
            case (off[4:0])
                S_MUX: smux_m[n] = v;
                S_CTL: sctl_m[n] = v;
                S_OP:  sop_m[n] = v;
                S_DC:  sdc_m[n] = v;
                default: ;
            endcase
        end
        else if (off >= 12'he00 && off <= 12'he1f) cmpc_m[off[4:2]] = v;
        else if (off >= 12'he40 && off <= 12'he5f) cmpr_m[off[4:2]] = v;
        else
            case (off)
                R_ACTSS: act_m = v & 32'hf;
                R_IM:    im_m = v;
                R_ISC:   ris_m = ris_m & ~v & 32'hf;
                R_OSTAT: ostat_m = ostat_m & ~v & 32'hf;
                R_EMUX:  emux_m = v;
                R_USTAT: ustat_m = ustat_m & ~v & 32'hf;
                R_TSSEL: tssel_m = v;
                R_SSPRI: pri_m = v;
                R_SPC:   spc_m = v;
                R_SAC:   sac_m = v;
                R_DCISC: dcisc_m = v;
                R_CTL:   ctl_m = v;
                R_DCRIC: dcric_m = v;
                R_PC:    pc_m = v;
                R_CC:    cc_m = v;
                default: ;
            endcase
    endtask

    // Advance the noise generator and push a sample for each armed sequencer
    task automatic fire_trigger();
        for (int n = 0; n < 4; n++)
        begin
            if (act_m[n] && emux_m[4*n +: 4] == TRIG_TIMER)
            begin
                noise_m = noise_m * NOISE_MUL + 32'd1;
                if (full_m[n])
                    ostat_m[n] = 1'b1;
                else
                begin
                    fifo_m[n][head_m[n]] = SAMPLE_BASE + {29'd0, noise_m[18:16]};
                    head_m[n] = head_m[n] + 4'd1;
                    empty_m[n] = 0;
                    if (tail_m[n] == head_m[n]) full_m[n] = 1;
                end
                ris_m[n] = 1'b1;
            end
        end
    endtask

    task automatic predict_txn(bus_txn_t t);
        bus_rsp_t r;
        r.rdata = 0;
        if (t.op == OP_READ) r.rdata = read_reg(t.offset);
        else if (t.op == OP_WRITE) write_reg(t.offset, t.wdata);
        else if (t.op == OP_TRIG) fire_trigger();
        r.irq = ris_m[3:0] & im_m[3:0];
        expected_rsps.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s at result %0d: got %h expected %h", what, rsp_count, got, want);
    endtask

    task automatic add_txn(logic [1:0] op, logic [11:0] off, logic [31:0] d);
        bus_txn_t t;
        t.op = op; t.offset = off; t.wdata = d;
        pending_txns.push_back(t);
    endtask

    // Pick a register offset, mostly legal and aligned
    function automatic logic [11:0] pick_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return 12'h040 + 12'($urandom_range(0, 3) * 32) + 12'h008;
        if (r < 50) return 12'h040 + 12'($urandom_range(0, 3) * 32) + 12'($urandom_range(0, 7) * 4);
        if (r < 75) return 12'($urandom_range(0, 14) * 4);
        if (r < 80) return 12'he00 + 12'($urandom_range(0, 31));
        if (r < 85) return 12'he40 + 12'($urandom_range(0, 31));
        if (r < 90) return 12'hfc0 + 12'($urandom_range(0, 3) * 4);
        if (r < 92) return R_DCRIC;
        return 12'($urandom_range(0, 4095));
    endfunction

    // Driver: present pending transactions with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            drv_gap  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_txn(pending_txns.pop_front());
            if (s_tvalid && !s_tready)
                ;
            else if (drv_gap > 0)
            begin
                s_tvalid <= 1'b0;
                drv_gap  <= drv_gap - 1;
            end
            else if (pending_txns.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_txns[0].op;
                s_tdata  <= {4'd0, pending_txns[0].wdata, pending_txns[0].offset};
                drv_gap  <= pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: stall at random and check each result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        bus_rsp_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            mon_gap  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
                else
                begin
                    want = expected_rsps.pop_front();
                    if (m_tdata[31:0] !== want.rdata)
                        report_mismatch("read_data", m_tdata[31:0], want.rdata);
                    if (m_tdata[35:32] !== want.irq)
                        report_mismatch("irq_lines", {28'd0, m_tdata[35:32]}, {28'd0, want.irq});
                end
                rsp_count++;
            end
            if (mon_gap > 0)
            begin
                m_tready <= 1'b0;
                mon_gap  <= mon_gap - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) mon_gap <= pick_gap();
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [31:0] d;
        int          r, k, seq;
        clk = 0; rst_n = 0; s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
        errors = 0; rsp_count = 0;
        n_reads = 0; n_writes = 0; n_trigs = 0;
        reset_shadow();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset values, empty pop, fill to overflow, drain, clears
        add_txn(OP_READ, R_SSPRI, 0);
        add_txn(OP_READ, R_PC, 0);
        add_txn(OP_READ, R_PERID, 0);
        add_txn(OP_READ, 12'h048, 32'hffff_ffff);
        add_txn(OP_READ, R_USTAT, 0);
        add_txn(OP_WRITE, R_ACTSS, 32'hffff_ffff);
        add_txn(OP_WRITE, R_EMUX, 32'h5555_5555);
        add_txn(OP_WRITE, R_IM, 32'hffff_ffff);
        add_txn(OP_WRITE, R_RIS, 32'hffff_ffff);
        add_txn(OP_WRITE, 12'h028, 32'hffff_ffff);
        add_txn(OP_READ, 12'h028, 0);
        add_txn(OP_WRITE, 12'h013, 32'hffff_ffff);
        add_txn(OP_READ, 12'h013, 0);
        for (int i = 0; i < 17; i++) add_txn(OP_TRIG, 12'hfff, 32'hffff_ffff);
        add_txn(OP_READ, 12'h04c, 0);
        add_txn(OP_READ, R_OSTAT, 0);
        add_txn(OP_WRITE, R_OSTAT, 32'hffff_ffff);
        for (int i = 0; i < 17; i++) add_txn(OP_READ, 12'h048, 0);
        add_txn(OP_WRITE, R_ISC, 32'h0000_0005);
        add_txn(OP_READ, R_ISC, 0);
        add_txn(OP_NOP, 12'h000, 32'hffff_ffff);
        add_txn(OP_WRITE, 12'he1f, 32'hdead_beef);
        add_txn(OP_READ, 12'he1c, 0);
        add_txn(OP_WRITE, R_DCRIC, 32'hffff_ffff);
        add_txn(OP_READ, R_DCRIC, 0);

        // Random: trigger and pop traffic on armed sequencers, mixed with other register traffic and noise
        for (int i = 0; i < 1850; i++)
        begin
            r = $urandom_range(0, 99);
            d = $urandom();
            if (r < 5)
            begin
                k = $urandom_range(0, 3);
                d = (k == 0) ? 32'h0 : (k == 1) ? 32'hffff_ffff : d;
            end
            if (r < 30)
            begin
                add_txn(OP_TRIG, pick_offset(), d);
                n_trigs++;
            end
            else if (r < 40)
            begin
                seq = $urandom_range(0, 3);
                add_txn(OP_READ, 12'h048 + 12'(seq * 32), d);
                n_reads++;
            end
            else if (r < 44)
            begin
                // Rearm: mostly timer triggers on random sequencers
                d = 0;
                for (int n = 0; n < 4; n++)
                    d[4*n +: 4] = ($urandom_range(0, 3) != 0) ? TRIG_TIMER : 4'($urandom());
                add_txn(OP_WRITE, R_EMUX, d);
                n_writes++;
            end
            else if (r < 47)
            begin
                add_txn(OP_WRITE, R_ACTSS, $urandom());
                n_writes++;
            end
            else if (r < 72)
            begin
                add_txn(OP_READ, pick_offset(), d);
                n_reads++;
            end
            else if (r < 98)
            begin
                add_txn(OP_WRITE, pick_offset(), d);
                n_writes++;
            end
            else
                add_txn(OP_NOP, 12'($urandom()), d);
        end
        wait (pending_txns.size() == 0 && expected_rsps.size() == 0);
        repeat (20) @(posedge clk);
        $display("covered %0d reads, %0d writes and %0d triggers after a directed pass",
                 n_reads, n_writes, n_trigs);
        $display("results checked: %0d, mismatches: %0d", rsp_count, errors);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/adcsq_pkg.sv
sv/adcsq_ram.sv
sv/adcsq_datapath.sv
sv/adcsq_ctrl.sv
sv/adc_sequencer_fifo_registers.sv
verif/tb_top.sv
